@@ hw/rtl/idalloc_pkg.sv @@
// Shared types and constants for the identifier allocator.
// No dependencies; imported by idalloc_ctrl, idalloc_dp and the top level.
`default_nettype none

package idalloc_pkg;

    localparam int IDENT_W  = 16;
    localparam int POS_W    = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = IDENT_W + 1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FRESH     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RECORDED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd7;

    localparam logic [CNT_W-1:0] CNT_RESET = 17'd1;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request beat, reset scan trackers
        logic scan_en;  // issue a table read this cycle
        logic commit;   // apply table update and load the result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic addr_last; // scan address is at the final entry
        logic out_free;  // result register can take a new beat
    } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/id_allocator_with_timed_reuse.sv @@
// Identifier allocator with a timed reuse table: top level joining controller and datapath.
// Allocate/release: idle, then a scan with one read of the table memory per cycle, then a
// compare drain and a commit, which waits until the result register is free.
// Clear and unknown requests go from idle straight to commit.
// Reset (aresetn, synchronous, active low): table empty, fresh counter at 1, no result pending.
// Depends on idalloc_pkg, idalloc_ctrl and idalloc_dp.
`default_nettype none

module id_allocator_with_timed_reuse #(
    parameter int TABLE_DEPTH = 16   // reuse table entries, 2 to 256
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // request channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [idalloc_pkg::REQ_W-1:0]      s_req_type,
    input  wire logic [idalloc_pkg::POS_W-1:0]      s_topo_pos,
    input  wire logic [idalloc_pkg::IDENT_W-1:0]    s_rel_ident,
    // result channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [idalloc_pkg::IDENT_W-1:0]         m_ident,
    output logic [idalloc_pkg::STATUS_W-1:0]        m_status
);
    import idalloc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Controller: idle -> scan (one table entry read per cycle) -> drain (last compare)
    // -> commit (waits for the result register to free up). Clear and unknown requests skip
    // scan and drain. A new beat is taken in idle while a result sits in the output register.
    idalloc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .cmd        (cmd),
        .sts        (sts)
    );

    // Datapath: identifier/position memory with registered read, valid flops,
    // lowest-identifier and first-free trackers, saturating fresh counter.
    idalloc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_req_type  (s_req_type),
        .s_topo_pos  (s_topo_pos),
        .s_rel_ident (s_rel_ident),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_ident     (m_ident),
        .m_status    (m_status)
    );

endmodule

`default_nettype wire

@@ hw/rtl/idalloc_ctrl.sv @@
// Sequencing state machine for the identifier allocator.
// Depends on idalloc_pkg; drives idalloc_dp through cmd_t / sts_t.
`default_nettype none

module idalloc_ctrl (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [idalloc_pkg::REQ_W-1:0]   s_req_type,
    output idalloc_pkg::cmd_t                    cmd,
    input  wire idalloc_pkg::sts_t               sts
);
    import idalloc_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.scan_en  = 1'b0;
        cmd.commit   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    if (s_req_type == REQ_ALLOC || s_req_type == REQ_RELEASE) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan_en = 1'b1;
                if (sts.addr_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/idalloc_dp.sv @@
// Datapath: reuse table memory, valid bits, scan trackers, fresh counter, result register.
// Depends on idalloc_pkg; commanded by idalloc_ctrl.
`default_nettype none

module idalloc_dp #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire idalloc_pkg::cmd_t                  cmd,
    output idalloc_pkg::sts_t                       sts,
    input  wire logic [idalloc_pkg::REQ_W-1:0]      s_req_type,
    input  wire logic [idalloc_pkg::POS_W-1:0]      s_topo_pos,
    input  wire logic [idalloc_pkg::IDENT_W-1:0]    s_rel_ident,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [idalloc_pkg::IDENT_W-1:0]         m_ident,
    output logic [idalloc_pkg::STATUS_W-1:0]        m_status
);
    import idalloc_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    // table storage
    logic [IDENT_W-1:0]     mem_ident [TABLE_DEPTH];
    logic [POS_W-1:0]       mem_pos   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;

    // captured request
    logic [REQ_W-1:0]   req_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [IDENT_W-1:0] rid_reg;

    // scan pipeline
    logic [IDX_W-1:0]   addr_reg;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDENT_W-1:0] rd_ident_reg;
    logic [POS_W-1:0]   rd_pos_reg;

    // trackers: best candidate (alloc) or matching entry (release), first free slot
    logic               found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [IDENT_W-1:0] hit_ident_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;

    logic [CNT_W-1:0]   counter_reg;

    logic               m_valid_reg;
    logic [IDENT_W-1:0] m_ident_reg;
    logic [STATUS_W-1:0] m_status_reg;

    logic               rd_entry_valid;
    logic               alloc_hit;
    logic               rel_hit;
    logic               is_alloc;
    logic               is_release;

    assign is_alloc       = (req_reg == REQ_ALLOC);
    assign is_release     = (req_reg == REQ_RELEASE);
    assign rd_entry_valid = valid_reg[rd_idx_reg];
    assign alloc_hit      = rd_entry_valid && (pos_reg > rd_pos_reg)
                            && (!found_reg || (rd_ident_reg < hit_ident_reg));
    assign rel_hit        = rd_entry_valid && (rd_ident_reg == rid_reg) && !found_reg;

    assign sts.addr_last = (addr_reg == IDX_LAST);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid  = m_valid_reg;
    assign m_ident  = m_ident_reg;
    assign m_status = m_status_reg;

    // memory read port
    always_ff @(posedge aclk) begin
        if (cmd.scan_en) begin
            rd_ident_reg <= mem_ident[addr_reg];
            rd_pos_reg   <= mem_pos[addr_reg];
            rd_idx_reg   <= addr_reg;
        end
    end

    // memory write port: overwrite in place on match, else fill first free slot
    always_ff @(posedge aclk) begin
        if (cmd.commit && is_release && (found_reg || free_found_reg)) begin
            mem_ident[found_reg ? hit_idx_reg : free_idx_reg] <= rid_reg;
            mem_pos[found_reg ? hit_idx_reg : free_idx_reg]   <= pos_reg;
        end
    end

    // request capture and scan trackers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_req_type;
            pos_reg <= s_topo_pos;
            rid_reg <= s_rel_ident;
        end
        if (rd_vld_reg && is_alloc && alloc_hit) begin
            hit_idx_reg   <= rd_idx_reg;
            hit_ident_reg <= rd_ident_reg;
        end
        if (rd_vld_reg && is_release && rel_hit) begin
            hit_idx_reg <= rd_idx_reg;
        end
        if (rd_vld_reg && !rd_entry_valid && !free_found_reg) begin
            free_idx_reg <= rd_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg       <= '0;
            rd_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_en;
            if (cmd.load) begin
                addr_reg       <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end else begin
                if (cmd.scan_en) begin
                    addr_reg <= addr_reg + IDX_W'(1);
                end
                if (rd_vld_reg && ((is_alloc && alloc_hit) || (is_release && rel_hit))) begin
                    found_reg <= 1'b1;
                end
                if (rd_vld_reg && !rd_entry_valid) begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    // valid bits and fresh counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            counter_reg <= CNT_RESET;
        end else if (cmd.commit) begin
            case (req_reg)
                REQ_ALLOC: begin
                    if (found_reg) begin
                        valid_reg[hit_idx_reg] <= 1'b0;
                    end else if (!counter_reg[CNT_W-1]) begin
                        counter_reg <= counter_reg + CNT_W'(1);
                    end
                end
                REQ_RELEASE: begin
                    if (!found_reg && free_found_reg) begin
                        valid_reg[free_idx_reg] <= 1'b1;
                    end
                end
                REQ_CLEAR: begin
                    valid_reg <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            case (req_reg)
                REQ_ALLOC: begin
                    if (found_reg) begin
                        m_ident_reg  <= hit_ident_reg;
                        m_status_reg <= ST_REUSED;
                    end else if (counter_reg[CNT_W-1]) begin
                        m_ident_reg  <= '0;
                        m_status_reg <= ST_EXHAUSTED;
                    end else begin
                        m_ident_reg  <= counter_reg[IDENT_W-1:0];
                        m_status_reg <= ST_FRESH;
                    end
                end
                REQ_RELEASE: begin
                    m_ident_reg  <= '0;
                    m_status_reg <= (found_reg || free_found_reg) ? ST_RECORDED : ST_DROPPED;
                end
                REQ_CLEAR: begin
                    m_ident_reg  <= '0;
                    m_status_reg <= ST_CLEARED;
                end
                default: begin
                    m_ident_reg  <= '0;
                    m_status_reg <= ST_UNKNOWN;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for id_allocator_with_timed_reuse: drives request beats and checks each
// reply against a cycle-free predictor of the reuse table and fresh counter.
// Depends on idalloc_pkg and the RTL of id_allocator_with_timed_reuse.
module tb_top;
    import idalloc_pkg::*;

    localparam int TABLE_DEPTH = 16;
    // req_type 3 has no name in the package; the block answers it with ST_UNKNOWN
    localparam logic [REQ_W-1:0] REQ_UNDEFINED = 2'd3;
    localparam logic [CNT_W-1:0] CNT_LAST_FRESH = 17'd65535;
    localparam logic [CNT_W-1:0] CNT_SATURATED = 17'd65536;
    localparam int DRAIN_CYCLES = 2 * (TABLE_DEPTH + 3);
    // the slowest correct run is dominated by the exhaustion sweep
    localparam int CYCLE_LIMIT = 5_000_000;

    typedef struct packed {
        logic [IDENT_W-1:0]  ident;
        logic [STATUS_W-1:0] status;
    } reply_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [REQ_W-1:0]    s_req_type = REQ_ALLOC;
    logic [POS_W-1:0]    s_topo_pos = '0;
    logic [IDENT_W-1:0]  s_rel_ident = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [IDENT_W-1:0]  m_ident;
    logic [STATUS_W-1:0] m_status;

    // predictor state: reuse table and fresh counter
    logic                tbl_valid [TABLE_DEPTH];
    logic [IDENT_W-1:0]  tbl_ident [TABLE_DEPTH];
    logic [POS_W-1:0]    tbl_pos   [TABLE_DEPTH];
    logic [CNT_W-1:0]    next_fresh;

    reply_t owed_replies [$];
    int     err_count = 0;
    int     cycle_count = 0;
    int     snd_idle_pct = 0;
    int     rcv_idle_pct = 0;

    id_allocator_with_timed_reuse #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_topo_pos  (s_topo_pos),
        .s_rel_ident (s_rel_ident),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_ident     (m_ident),
        .m_status    (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------------------------------
    // Predictor. Allocation takes the valid entry with the smallest identifier among those
    // whose stored position is strictly below the request's; otherwise a fresh value, which
    // saturates once 65535 has been handed out. Release overwrites a matching identifier in
    // place (even when full), else fills the lowest free slot, else is dropped.
    // ---------------------------------------------------------------------------------------
    function automatic void clear_tables();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_ident[i] = '0;
            tbl_pos[i]   = '0;
        end
    endfunction

    function automatic void serve_request(input logic [REQ_W-1:0] req,
                                          input logic [POS_W-1:0] pos,
                                          input logic [IDENT_W-1:0] rid,
                                          output logic [IDENT_W-1:0] id,
                                          output logic [STATUS_W-1:0] st);
        int best;
        int slot;
        best = -1;
        slot = -1;
        id   = '0;
        case (req)
            REQ_ALLOC: begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (tbl_valid[i] && pos > tbl_pos[i]) begin
                        if (best < 0 || tbl_ident[i] < tbl_ident[best])
                            best = i;
                    end
                end
                if (best >= 0) begin
                    tbl_valid[best] = 1'b0;
                    id = tbl_ident[best];
                    st = ST_REUSED;
                end else if (next_fresh > CNT_LAST_FRESH) begin
                    next_fresh = CNT_SATURATED;
                    st = ST_EXHAUSTED;
                end else begin
                    id = next_fresh[IDENT_W-1:0];
                    st = ST_FRESH;
                    next_fresh = next_fresh + CNT_W'(1);
                end
            end
            REQ_RELEASE: begin
                st = ST_DROPPED;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (best < 0 && tbl_valid[i] && tbl_ident[i] == rid)
                        best = i;
                    if (slot < 0 && !tbl_valid[i])
                        slot = i;
                end
                if (best >= 0) begin
                    tbl_pos[best] = pos;
                    st = ST_RECORDED;
                end else if (slot >= 0) begin
                    tbl_valid[slot] = 1'b1;
                    tbl_ident[slot] = rid;
                    tbl_pos[slot]   = pos;
                    st = ST_RECORDED;
                end
            end
            REQ_CLEAR: begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    tbl_valid[i] = 1'b0;
                st = ST_CLEARED;
            end
            default: begin
                st = ST_UNKNOWN;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
        err_count++;
    endtask

    // ---------------------------------------------------------------------------------------
    // Monitor: both channels sampled at the rising edge. A request beat updates the predictor
    // and queues its reply; a reply beat is checked against the oldest one queued.
    // ---------------------------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [IDENT_W-1:0]  want_id;
        logic [STATUS_W-1:0] want_st;
        reply_t              oldest;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                serve_request(s_req_type, s_topo_pos, s_rel_ident, want_id, want_st);
                owed_replies.push_back('{ident: want_id, status: want_st});
            end
            if (m_valid && m_ready) begin
                if (owed_replies.size() == 0) begin
                    report_mismatch("reply beat with none owed, ident", 32'(m_ident), '0);
                end else begin
                    oldest = owed_replies.pop_front();
                    if (m_ident !== oldest.ident)
                        report_mismatch("ident", 32'(m_ident), 32'(oldest.ident));
                    if (m_status !== oldest.status)
                        report_mismatch("status", 32'(m_status), 32'(oldest.status));
                end
            end
        end
    end

    // receiver back-pressure, redrawn every cycle at the falling edge
    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= rcv_idle_pct);

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("id_allocator_with_timed_reuse: mismatch");
            $finish;
        end
    end

    // Sends one request beat. Entered and left just after a falling edge; valid is only
    // dropped for a sender gap, so back-to-back beats keep it high.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                                input logic [IDENT_W-1:0] rid);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_topo_pos  <= pos;
        s_rel_ident <= rid;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        while (owed_replies.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // first fresh value, position 0 allocation and the undefined request code
    task automatic test_fresh_and_unknown();
        send_request(REQ_ALLOC, 32'h0000_0000, 16'h0000);
        send_request(REQ_UNDEFINED, 32'hFFFF_FFFF, 16'hFFFF);
    endtask

    // fill all slots (identifiers 0 and 0xFFFF among them), drop one more, then overwrite a
    // present identifier while the table is full
    task automatic test_table_full();
        send_request(REQ_RELEASE, 32'h0000_0000, 16'h0000);
        send_request(REQ_RELEASE, 32'hFFFF_FFFE, 16'hFFFF);
        for (int i = 0; i < TABLE_DEPTH - 2; i++)
            send_request(REQ_RELEASE, 32'(i + 1), 16'(16'h0100 + i));
        send_request(REQ_RELEASE, 32'h0000_0001, 16'h01F4);
        send_request(REQ_RELEASE, 32'h0000_0003, 16'hFFFF);
    endtask

    // strict comparison, smallest identifier first, identifier 0 reused, clear keeps counter
    task automatic test_reuse_and_clear();
        send_request(REQ_ALLOC, 32'h0000_0000, 16'h5555);
        send_request(REQ_ALLOC, 32'h0000_0004, 16'hAAAA);
        send_request(REQ_ALLOC, 32'hFFFF_FFFF, 16'h0000);
        send_request(REQ_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(REQ_ALLOC, 32'hFFFF_FFFF, 16'h0000);
    endtask

    // Random traffic in runs of 40 beats, each run release-heavy, allocate-heavy or even, so
    // the table fills, drops and drains. Identifiers and positions come mostly from small
    // ranges so that overwrites and position matches are common.
    task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct);
        int                 mode;
        int                 rel_pct;
        int                 r;
        logic [REQ_W-1:0]   req;
        logic [POS_W-1:0]   pos;
        logic [IDENT_W-1:0] rid;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        rel_pct = 48;
        for (int k = 0; k < n_items; k++) begin
            if (k % 40 == 0) begin
                mode = $urandom_range(2);
                rel_pct = (mode == 0) ? 70 : (mode == 1) ? 25 : 48;
            end
            r = $urandom_range(99);
            if (r < 3)
                req = REQ_CLEAR;
            else if (r < 5)
                req = REQ_UNDEFINED;
            else if ($urandom_range(99) < rel_pct)
                req = REQ_RELEASE;
            else
                req = REQ_ALLOC;

            r = $urandom_range(99);
            if (r < 85)
                rid = 16'($urandom_range(47));
            else if (r < 95)
                rid = 16'($urandom);
            else
                rid = $urandom_range(1) ? 16'hFFFF : 16'h0000;

            r = $urandom_range(99);
            if (r < 70) begin
                pos = 32'($urandom_range(63));
            end else if (r < 85) begin
                pos = $urandom;
            end else begin
                case ($urandom_range(3))
                    0:       pos = 32'h0000_0000;
                    1:       pos = 32'h0000_0001;
                    2:       pos = 32'hFFFF_FFFE;
                    default: pos = 32'hFFFF_FFFF;
                endcase
            end
            send_request(req, pos, rid);
        end
    endtask

    // Run the fresh counter out. Position 0 never matches a table entry, so every allocation
    // here is fresh until the counter saturates. Then reuse must still work.
    task automatic test_counter_exhaustion();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        send_request(REQ_CLEAR, 32'h0000_0000, 16'h0000);
        // predictor is current here: send_request returns after the accepting edge
        while (next_fresh <= CNT_LAST_FRESH)
            send_request(REQ_ALLOC, 32'h0000_0000, 16'($urandom));
        send_request(REQ_ALLOC, 32'hFFFF_FFFF, 16'h0000);
        send_request(REQ_ALLOC, 32'h0000_0000, 16'hFFFF);
        send_request(REQ_RELEASE, 32'h0000_0001, 16'h0007);
        send_request(REQ_ALLOC, 32'h0000_0002, 16'h0000);
        send_request(REQ_ALLOC, 32'hFFFF_FFFF, 16'h0000);
    endtask

    initial begin
        clear_tables();
        next_fresh = CNT_RESET;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        snd_idle_pct = 12;
        rcv_idle_pct = 50;
        test_fresh_and_unknown();
        test_table_full();
        test_reuse_and_clear();

        test_random_traffic(530, 12, 50);
        test_random_traffic(530, 50, 12);
        test_random_traffic(540, 0, 0);
        test_counter_exhaustion();

        s_valid <= 1'b0;
        wait_drain();
        if (owed_replies.size() != 0)
            report_mismatch("replies still owed at end", 32'(owed_replies.size()), '0);

        if (err_count == 0) begin
            $display("id_allocator_with_timed_reuse: match");
        end else begin
            $display("id_allocator_with_timed_reuse: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/idalloc_pkg.sv
hw/rtl/idalloc_ctrl.sv
hw/rtl/idalloc_dp.sv
hw/rtl/id_allocator_with_timed_reuse.sv
bench/tb_top.sv
